/* hdl/tt_pkg.sv */
package tt_pkg;

  // widest cell address over the whole parameter range (128 x 64 cells)
  localparam int MAX_ADDR_W = 13;

  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] FILL_RESET = 8'h07;

  typedef enum logic [2:0] {
    MODE_PUT     = 3'd0,
    MODE_BS      = 3'd1,
    MODE_CLEAR   = 3'd2,
    MODE_SNAP    = 3'd3,
    MODE_RESTORE = 3'd4,
    MODE_UP      = 3'd5,
    MODE_DOWN    = 3'd6,
    MODE_READ    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    MEM_SCREEN = 2'd0,
    MEM_SAVED  = 2'd1,
    MEM_HIST   = 2'd2
  } mem_sel_t;

  typedef struct packed {
    logic                  start;
    mem_sel_t              src;
    logic                  src_const;
    logic [15:0]           fill;
    mem_sel_t              dst;
    logic [MAX_ADDR_W-1:0] src_base;
    logic [MAX_ADDR_W-1:0] dst_base;
    logic [MAX_ADDR_W:0]   count;
    logic                  desc;
  } sweep_cmd_t;

  typedef struct packed {
    logic                  rd_en;
    mem_sel_t              rd_sel;
    logic [MAX_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    mem_sel_t              wr_sel;
    logic [MAX_ADDR_W-1:0] wr_addr;
    logic                  wr_const;
    logic [15:0]           wr_data;
  } mem_req_t;

endpackage

/* hdl/tt_sweep.sv */
module tt_sweep (
  input  logic                 clk,
  input  logic                 rst,
  input  tt_pkg::sweep_cmd_t   cmd,
  output tt_pkg::mem_req_t     req,
  output logic                 busy
);
  import tt_pkg::*;

  logic                  active;
  logic                  wv;
  mem_sel_t              src_sel;
  mem_sel_t              dst_sel;
  logic                  src_const;
  logic [15:0]           fill;
  logic [MAX_ADDR_W-1:0] src_addr;
  logic [MAX_ADDR_W-1:0] dst_addr;
  logic [MAX_ADDR_W-1:0] w_addr;
  logic [MAX_ADDR_W:0]   remaining;
  logic                  desc;
  logic [MAX_ADDR_W-1:0] last_off;

  assign busy     = active | wv;
  assign last_off = cmd.count[MAX_ADDR_W-1:0] - MAX_ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      wv     <= 1'b0;
    end else begin
      wv <= active;
      if (active) begin
        w_addr <= dst_addr;
      end
      if (cmd.start && !busy) begin
        active    <= 1'b1;
        src_sel   <= cmd.src;
        dst_sel   <= cmd.dst;
        src_const <= cmd.src_const;
        fill      <= cmd.fill;
        desc      <= cmd.desc;
        remaining <= cmd.count;
        src_addr  <= cmd.desc ? cmd.src_base + last_off : cmd.src_base;
        dst_addr  <= cmd.desc ? cmd.dst_base + last_off : cmd.dst_base;
      end else if (active) begin
        if (remaining == (MAX_ADDR_W+1)'(1)) begin
          active <= 1'b0;
        end
        remaining <= remaining - (MAX_ADDR_W+1)'(1);
        src_addr  <= desc ? src_addr - MAX_ADDR_W'(1) : src_addr + MAX_ADDR_W'(1);
        dst_addr  <= desc ? dst_addr - MAX_ADDR_W'(1) : dst_addr + MAX_ADDR_W'(1);
      end
    end
  end

  always_comb begin
    req.rd_en    = active;
    req.rd_sel   = src_sel;
    req.rd_addr  = src_addr;
    req.wr_en    = wv;
    req.wr_sel   = dst_sel;
    req.wr_addr  = w_addr;
    req.wr_const = src_const;
    req.wr_data  = fill;
  end

endmodule

/* hdl/tt_store.sv */
module tt_store #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 24,
  parameter int HISTORY_ROWS = 24
) (
  input  logic             clk,
  input  tt_pkg::mem_req_t sweep_req,
  input  tt_pkg::mem_req_t host_req,
  output logic [15:0]      rdata
);
  import tt_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int HCELLS = HISTORY_ROWS * COLUMNS;
  localparam int SAW    = $clog2(CELLS);
  localparam int HAW    = $clog2(HCELLS);

  logic [15:0] scr_mem  [CELLS];
  logic [15:0] sav_mem  [CELLS];
  logic [15:0] hist_mem [HCELLS];

  logic [15:0] scr_q;
  logic [15:0] sav_q;
  logic [15:0] hist_q;
  mem_sel_t    sel_d;
  mem_req_t    rd;
  mem_req_t    wr;
  logic [15:0] wdata;

  assign rd    = sweep_req.rd_en ? sweep_req : host_req;
  assign wr    = sweep_req.wr_en ? sweep_req : host_req;
  assign wdata = wr.wr_const ? wr.wr_data : rdata;

  always_ff @(posedge clk) begin
    scr_q  <= scr_mem[rd.rd_addr[SAW-1:0]];
    sav_q  <= sav_mem[rd.rd_addr[SAW-1:0]];
    hist_q <= hist_mem[rd.rd_addr[HAW-1:0]];
    sel_d  <= rd.rd_sel;
    if (wr.wr_en) begin
      unique case (wr.wr_sel)
        MEM_SCREEN: scr_mem[wr.wr_addr[SAW-1:0]]  <= wdata;
        MEM_SAVED:  sav_mem[wr.wr_addr[SAW-1:0]]  <= wdata;
        MEM_HIST:   hist_mem[wr.wr_addr[HAW-1:0]] <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_d)
      MEM_SCREEN: rdata = scr_q;
      MEM_SAVED:  rdata = sav_q;
      MEM_HIST:   rdata = hist_q;
      default:    rdata = 16'd0;
    endcase
  end

endmodule

/* hdl/text_terminal_with_scrollback.sv */
// character-cell text terminal with a scrollback ring
//
// input channel s_axis: one item is one command; tuser carries the mode and
// tdata carries the character, attribute and read coordinates
// output channel m_axis: exactly one result item per command, in order
// cfg_we/cfg_wdata: writes the fill attribute used by clear and by scrolls
//
// all screen moves run through one copy/fill sweep unit that touches one
// cell per clock
// work done for each item after it is accepted:
//   put char / backspace: the history, shift and blank sweeps first when a pending
//   scroll is carried out, then the cell write; backspace at origin: no write
//   clear, snapshot, restore, view down to zero: one full-screen sweep
//   view up / view down: a shift sweep, then a line sweep; none when refused
//   read: one registered cell read
// the block takes one item at a time; s_axis_tready is high only when idle,
// from the cycle after the previous result is written
// the result sits in an output register, so a new item is taken while the
// previous result still waits; a stalled receiver holds the block before
// its next result is written
// after reset the screen and snapshot stores are zeroed by one sweep each;
// no item is taken meanwhile
module text_terminal_with_scrollback #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 24,
  parameter int HISTORY_ROWS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [15:8] char_attribute, [20:16] read_row,
  // [27:21] read_col, rest zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [16:12] view_offset,
  // [24:17] cell_char, [32:25] cell_attribute, [33] refused, rest zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import tt_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int XW    = $clog2(COLUMNS);
  localparam int YW    = $clog2(ROWS + 1);
  localparam int HW    = $clog2(HISTORY_ROWS + 1);
  localparam int AW    = MAX_ADDR_W;

  localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A  = AW'(CELLS - COLUMNS);
  localparam logic [AW:0]   CNT_ALL = (AW+1)'(CELLS);
  localparam logic [AW:0]   CNT_SH  = (AW+1)'(CELLS - COLUMNS);
  localparam logic [AW:0]   CNT_ROW = (AW+1)'(COLUMNS);

  typedef enum logic [16:0] {
    ST_INIT_SCR = 17'h00001,
    ST_INIT_SAV = 17'h00002,
    ST_IDLE     = 17'h00004,
    ST_DECODE   = 17'h00008,
    ST_SC_HIST  = 17'h00010,
    ST_SC_SHIFT = 17'h00020,
    ST_SC_BLANK = 17'h00040,
    ST_PUT      = 17'h00080,
    ST_BS_WRITE = 17'h00100,
    ST_COPY     = 17'h00200,
    ST_VU_SHIFT = 17'h00400,
    ST_VU_LINE  = 17'h00800,
    ST_VD_SHIFT = 17'h01000,
    ST_VD_LINE  = 17'h02000,
    ST_READ     = 17'h04000,
    ST_RDATA    = 17'h08000,
    ST_FIN      = 17'h10000
  } state_t;

  state_t      state;
  logic        launched;
  logic        sweep_busy;
  sweep_cmd_t  cmd;
  mem_req_t    sweep_req;
  mem_req_t    host_req;
  logic [15:0] rdata;

  // architectural state
  logic [7:0]    fill_attribute;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [YW-1:0] vb;
  logic [HW-1:0] head;
  logic [HW-1:0] hfill;

  // held item and result
  mode_t       it_mode;
  logic [7:0]  it_char;
  logic [7:0]  it_attr;
  logic [4:0]  it_rr;
  logic [6:0]  it_rc;
  logic [15:0] cell_data;
  logic        refused;

  logic [XW-1:0] xc;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_addr;
  logic [HW:0]   hsum;
  logic [HW:0]   hrow;
  logic [YW-1:0] vd_row;
  logic [15:0]   blank_fill;
  logic          is_newline;
  logic          in_range;
  logic          sweep_done;

  assign s_axis_tready = (state == ST_IDLE);
  assign xc         = (cx >= XW'(COLUMNS - 1)) ? XW'(COLUMNS - 1) : cx;
  assign cur_addr   = AW'(cy) * COLS_A + AW'(xc);
  assign rd_addr    = AW'(it_rr) * COLS_A + AW'(it_rc);
  assign in_range   = (32'(it_rr) < 32'(ROWS)) && (32'(it_rc) < 32'(COLUMNS));
  assign hsum       = (HW+1)'(head) + (HW+1)'(HISTORY_ROWS) - (HW+1)'(vb);
  assign hrow       = (hsum >= (HW+1)'(HISTORY_ROWS)) ? hsum - (HW+1)'(HISTORY_ROWS) : hsum;
  assign vd_row     = YW'(ROWS - 1) - vb;
  assign blank_fill = {fill_attribute, CH_BLANK};
  assign is_newline = (it_char == CH_LF) || (it_char == CH_CR);
  assign sweep_done = launched && !sweep_busy;

  // sweep command for each sweeping state
  always_comb begin
    cmd           = '0;
    cmd.start     = !launched;
    cmd.src       = MEM_SCREEN;
    cmd.dst       = MEM_SCREEN;
    unique case (state)
      ST_INIT_SCR: begin
        cmd.src_const = 1'b1;
        cmd.count     = CNT_ALL;
      end
      ST_INIT_SAV: begin
        cmd.src_const = 1'b1;
        cmd.dst       = MEM_SAVED;
        cmd.count     = CNT_ALL;
      end
      ST_SC_HIST: begin
        cmd.dst      = MEM_HIST;
        cmd.dst_base = AW'(head) * COLS_A;
        cmd.count    = CNT_ROW;
      end
      ST_SC_SHIFT, ST_VD_SHIFT: begin
        cmd.src_base = COLS_A;
        cmd.count    = CNT_SH;
      end
      ST_SC_BLANK: begin
        cmd.src_const = 1'b1;
        cmd.fill      = blank_fill;
        cmd.dst_base  = LAST_A;
        cmd.count     = CNT_ROW;
      end
      ST_COPY: begin
        cmd.count = CNT_ALL;
        case (it_mode)
          MODE_CLEAR: begin
            cmd.src_const = 1'b1;
            cmd.fill      = blank_fill;
          end
          MODE_SNAP: cmd.dst = MEM_SAVED;
          default:   cmd.src = MEM_SAVED;
        endcase
      end
      ST_VU_SHIFT: begin
        cmd.dst_base = COLS_A;
        cmd.count    = CNT_SH;
        cmd.desc     = 1'b1;
      end
      ST_VU_LINE: begin
        cmd.src      = MEM_HIST;
        cmd.src_base = AW'(hrow) * COLS_A;
        cmd.count    = CNT_ROW;
      end
      ST_VD_LINE: begin
        cmd.src      = MEM_SAVED;
        cmd.src_base = AW'(vd_row) * COLS_A;
        cmd.dst_base = LAST_A;
        cmd.count    = CNT_ROW;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  // single cell accesses: char writes, backspace blank, cell read
  always_comb begin
    host_req          = '0;
    host_req.rd_sel   = MEM_SCREEN;
    host_req.wr_sel   = MEM_SCREEN;
    host_req.wr_const = 1'b1;
    host_req.wr_addr  = cur_addr;
    host_req.rd_addr  = rd_addr;
    host_req.rd_en    = (state == ST_READ);
    if (state == ST_PUT) begin
      host_req.wr_en   = !is_newline;
      host_req.wr_data = {it_attr, it_char};
    end else if (state == ST_BS_WRITE) begin
      host_req.wr_en   = 1'b1;
      host_req.wr_data = {it_attr, CH_BLANK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT_SCR;
      launched       <= 1'b0;
      fill_attribute <= FILL_RESET;
      cx             <= '0;
      cy             <= '0;
      vb             <= '0;
      head           <= '0;
      hfill          <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_attribute <= cfg_wdata;
      end
      // the final state sets the next result itself
      if (m_axis_tvalid && m_axis_tready && state != ST_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.start) begin
        launched <= 1'b1;
      end else if (sweep_done) begin
        launched <= 1'b0;
      end

      unique case (state)
        ST_INIT_SCR: if (sweep_done) state <= ST_INIT_SAV;
        ST_INIT_SAV: if (sweep_done) state <= ST_IDLE;
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            it_mode <= mode_t'(s_axis_tuser);
            it_char <= s_axis_tdata[7:0];
            it_attr <= s_axis_tdata[15:8];
            it_rr   <= s_axis_tdata[20:16];
            it_rc   <= s_axis_tdata[27:21];
            state   <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          cell_data <= '0;
          refused   <= 1'b0;
          unique case (it_mode)
            MODE_PUT: state <= (cy >= YW'(ROWS)) ? ST_SC_HIST : ST_PUT;
            MODE_BS: begin
              if (cx == '0) begin
                if (cy == '0) begin
                  state <= ST_FIN;
                end else begin
                  // from the pending row this lands on the last row
                  cy    <= (cy - YW'(1) >= YW'(ROWS)) ? YW'(ROWS - 1) : cy - YW'(1);
                  cx    <= XW'(COLUMNS - 1);
                  state <= ST_BS_WRITE;
                end
              end else begin
                cx    <= xc - XW'(1);
                state <= (cy >= YW'(ROWS)) ? ST_SC_HIST : ST_BS_WRITE;
              end
            end
            MODE_CLEAR: begin
              cx    <= '0;
              cy    <= '0;
              state <= ST_COPY;
            end
            MODE_SNAP, MODE_RESTORE: state <= ST_COPY;
            MODE_UP: begin
              if (vb >= YW'(ROWS) || 32'(vb) >= 32'(hfill)) begin
                refused <= 1'b1;
                state   <= ST_FIN;
              end else begin
                vb    <= vb + YW'(1);
                state <= ST_VU_SHIFT;
              end
            end
            MODE_DOWN: begin
              if (vb == '0) begin
                refused <= 1'b1;
                state   <= ST_FIN;
              end else begin
                vb    <= vb - YW'(1);
                // back at the live view: the whole snapshot returns
                state <= (vb == YW'(1)) ? ST_COPY : ST_VD_SHIFT;
              end
            end
            MODE_READ: state <= in_range ? ST_READ : ST_FIN;
            default:   state <= ST_FIN;
          endcase
        end
        ST_SC_HIST:  if (sweep_done) state <= ST_SC_SHIFT;
        ST_SC_SHIFT: if (sweep_done) state <= ST_SC_BLANK;
        ST_SC_BLANK: begin
          if (sweep_done) begin
            head <= (head == HW'(HISTORY_ROWS - 1)) ? '0 : head + HW'(1);
            if (hfill < HW'(HISTORY_ROWS)) begin
              hfill <= hfill + HW'(1);
            end
            cy    <= YW'(ROWS - 1);
            state <= (it_mode == MODE_PUT) ? ST_PUT : ST_BS_WRITE;
          end
        end
        ST_PUT: begin
          if (is_newline) begin
            cy <= cy + YW'(1);
            cx <= '0;
          end else if (xc == XW'(COLUMNS - 1)) begin
            cx <= '0;
            cy <= cy + YW'(1);
          end else begin
            cx <= xc + XW'(1);
          end
          state <= ST_FIN;
        end
        ST_BS_WRITE: state <= ST_FIN;
        ST_COPY:     if (sweep_done) state <= ST_FIN;
        ST_VU_SHIFT: if (sweep_done) state <= ST_VU_LINE;
        ST_VU_LINE:  if (sweep_done) state <= ST_FIN;
        ST_VD_SHIFT: if (sweep_done) state <= ST_VD_LINE;
        ST_VD_LINE:  if (sweep_done) state <= ST_FIN;
        ST_READ:     state <= ST_RDATA;
        ST_RDATA: begin
          cell_data <= rdata;
          state     <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, refused, cell_data, 5'(vb), 5'(cy), 7'(cx)};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  tt_sweep u_sweep (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (sweep_req),
    .busy (sweep_busy)
  );

  tt_store #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_store (
    .clk       (clk),
    .sweep_req (sweep_req),
    .host_req  (host_req),
    .rdata     (rdata)
  );

endmodule

/* hdl/tt_checker.sv */
module tt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after an accepted item");

  // a refused scroll carries no cell
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32:17] == 16'd0)
    else $error("refused result with cell data");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("padding bits set");

endmodule

bind text_terminal_with_scrollback tt_checker u_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tt_pkg::*;

  localparam int COLS   = 80;
  localparam int LINES  = 24;
  localparam int HIST   = 24;
  localparam int NCELLS = COLS * LINES;
  // sized well above the slowest item (a scroll sweep plus both idle bursts)
  // times up to ~700 items, plus the clearing sweeps after reset
  localparam int CYCLE_LIMIT = 10_000_000;

  // one command item as sent on s_axis
  typedef struct {
    mode_t      mode;
    logic [7:0] code;
    logic [7:0] attr;
    logic [4:0] row;
    logic [6:0] col;
  } command_t;

  // one result item as seen on m_axis
  typedef struct {
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [4:0] view;
    logic [7:0] cell_ch;
    logic [7:0] cell_at;
    logic       refused;
  } status_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [7:0] char_code, [15:8] char_attribute, [20:16] read_row, [27:21] read_col
  logic [31:0] s_axis_tdata;
  // [2:0] mode
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [6:0] cursor_col, [11:7] cursor_row, [16:12] view_offset,
  // [24:17] cell_char, [32:25] cell_attribute, [33] refused
  logic [39:0] m_axis_tdata;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  text_terminal_with_scrollback u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  command_t pending_cmds[$];
  status_t  expected_status[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       quiet_tail  = 0;   // no idling in the last stretch
  bit       cmd_taken   = 0;   // s_axis handshake seen at the last rising edge

  // ---------------------------------------------------------------------------
  // terminal shadow: screen, snapshot, history ring and cursor
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_screen[NCELLS];
  logic [15:0] shadow_saved[NCELLS];
  logic [15:0] shadow_hist[HIST * COLS];
  int          cur_x, cur_y, view_back, hist_head, hist_fill;
  logic [7:0]  fill_attr;

  function automatic logic [15:0] blank_cell(logic [7:0] a);
    return {a, CH_BLANK};
  endfunction

  // push the top line into history, move the rest up, blank the bottom line
  function automatic void push_top_line();
    for (int i = 0; i < COLS; i++) shadow_hist[hist_head * COLS + i] = shadow_screen[i];
    hist_head = (hist_head + 1) % HIST;
    if (hist_fill < HIST) hist_fill++;
    for (int i = 0; i < NCELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
    for (int i = NCELLS - COLS; i < NCELLS; i++) shadow_screen[i] = blank_cell(fill_attr);
  endfunction

  function automatic void settle_scroll();
    if (cur_y >= LINES) begin
      push_top_line();
      cur_y = LINES - 1;
    end
  endfunction

  // apply one command to the shadow and return the status it must produce
  function automatic status_t terminal_step(command_t c);
    status_t     s;
    logic [15:0] cell_word;
    bit          refused;
    int          src;
    cell_word = '0;
    refused   = 0;
    case (c.mode)
      MODE_PUT: begin
        settle_scroll();
        if (c.code == CH_LF || c.code == CH_CR) begin
          cur_y++;
          cur_x = 0;
        end else begin
          if (cur_x >= COLS) cur_x = COLS - 1;
          shadow_screen[cur_y * COLS + cur_x] = {c.attr, c.code};
          cur_x++;
          if (cur_x >= COLS) begin
            cur_x = 0;
            cur_y++;
          end
        end
      end
      MODE_BS: begin
        if (!(cur_x == 0 && cur_y == 0)) begin
          if (cur_x == 0) begin
            // to the last column of the row above, pending scroll dropped
            cur_y--;
            if (cur_y >= LINES) cur_y = LINES - 1;
            cur_x = COLS - 1;
          end else begin
            cur_x--;
            settle_scroll();
          end
          shadow_screen[cur_y * COLS + cur_x] = blank_cell(c.attr);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) shadow_screen[i] = blank_cell(fill_attr);
        cur_x = 0;
        cur_y = 0;
      end
      MODE_SNAP:    shadow_saved  = shadow_screen;
      MODE_RESTORE: shadow_screen = shadow_saved;
      MODE_UP: begin
        if (view_back >= LINES || view_back >= hist_fill) refused = 1;
        else begin
          view_back++;
          for (int i = NCELLS - 1; i >= COLS; i--) shadow_screen[i] = shadow_screen[i - COLS];
          src = ((hist_head + HIST - view_back) % HIST) * COLS;
          for (int i = 0; i < COLS; i++) shadow_screen[i] = shadow_hist[src + i];
        end
      end
      MODE_DOWN: begin
        if (view_back == 0) refused = 1;
        else begin
          view_back--;
          if (view_back == 0) shadow_screen = shadow_saved;
          else begin
            for (int i = 0; i < NCELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            src = ((LINES - 1 - view_back) % LINES) * COLS;
            for (int i = 0; i < COLS; i++)
              shadow_screen[NCELLS - COLS + i] = shadow_saved[src + i];
          end
        end
      end
      default: begin
        if (c.row < LINES && c.col < COLS) cell_word = shadow_screen[c.row * COLS + c.col];
      end
    endcase
    s.cur_col = cur_x[6:0];
    s.cur_row = cur_y[4:0];
    s.view    = view_back[4:0];
    s.cell_ch = cell_word[7:0];
    s.cell_at = cell_word[15:8];
    s.refused = refused;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // command generation
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(mode_t m, logic [7:0] code, logic [7:0] attr,
                                    logic [4:0] row, logic [6:0] col);
    command_t c;
    c.mode = m;
    c.code = code;
    c.attr = attr;
    c.row  = row;
    c.col  = col;
    pending_cmds.push_back(c);
  endfunction

  // non-put commands still carry random payload so every bit toggles
  function automatic void queue_op(mode_t m);
    queue_cmd(m, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
  endfunction

  function automatic void queue_read();
    if ($urandom_range(0, 4) == 0)
      queue_cmd(MODE_READ, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    else queue_cmd(MODE_READ, 8'($urandom), 8'($urandom), 5'($urandom_range(0, LINES - 1)),
                   7'($urandom_range(0, COLS - 1)));
  endfunction

  // random session of realistic console traffic: text, line feeds that scroll,
  // backspaces, view tours through history, snapshots and reads
  function automatic void queue_session(int n_items);
    int start, k;
    start = pending_cmds.size();
    while (pending_cmds.size() - start < n_items) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin  // text run, wraps lines
          k = $urandom_range(1, 90);
          repeat (k) queue_cmd(MODE_PUT, 8'($urandom_range(0, 255)), 8'($urandom),
                               5'($urandom), 7'($urandom));
        end
        3, 4: begin     // line feeds and carriage returns, drive scrolls
          k = $urandom_range(1, 12);
          repeat (k) queue_cmd(MODE_PUT, $urandom_range(0, 1) ? CH_LF : CH_CR,
                               8'($urandom), 5'($urandom), 7'($urandom));
        end
        5: begin
          k = $urandom_range(1, 6);
          repeat (k) queue_op(MODE_BS);
        end
        6: begin        // view tour: up past the limit, then back down past zero
          queue_op(MODE_SNAP);
          k = $urandom_range(1, 26);
          repeat (k) queue_op(MODE_UP);
          repeat ($urandom_range(1, 3)) queue_read();
          repeat (k + $urandom_range(0, 1)) queue_op(MODE_DOWN);
        end
        7, 8: repeat ($urandom_range(1, 5)) queue_read();
        9:  queue_op($urandom_range(0, 1) ? MODE_SNAP : MODE_RESTORE);
        10: if ($urandom_range(0, 3) == 0) queue_op(MODE_CLEAR);
        default: queue_op(mode_t'($urandom_range(0, 7)));  // noise
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: s_axis from the pending queue, m_axis_tready with random stalls
  // ---------------------------------------------------------------------------
  int send_gap  = 0;
  int stall_gap = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || cmd_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          command_t c;
          c = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= c.mode;
          s_axis_tdata  <= {4'b0, c.col, c.row, c.attr, c.code};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_gap = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted command, check each accepted result
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", field, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      cmd_taken = !rst && s_axis_tvalid && s_axis_tready;
      if (cmd_taken) begin
        command_t c;
        c.mode = mode_t'(s_axis_tuser);
        c.code = s_axis_tdata[7:0];
        c.attr = s_axis_tdata[15:8];
        c.row  = s_axis_tdata[20:16];
        c.col  = s_axis_tdata[27:21];
        expected_status.push_back(terminal_step(c));
      end
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          status_t w;
          w = expected_status.pop_front();
          if (m_axis_tdata[6:0]   !== w.cur_col) report_mismatch("cursor_col", m_axis_tdata[6:0], w.cur_col);
          if (m_axis_tdata[11:7]  !== w.cur_row) report_mismatch("cursor_row", m_axis_tdata[11:7], w.cur_row);
          if (m_axis_tdata[16:12] !== w.view)    report_mismatch("view_offset", m_axis_tdata[16:12], w.view);
          if (m_axis_tdata[24:17] !== w.cell_ch) report_mismatch("cell_char", m_axis_tdata[24:17], w.cell_ch);
          if (m_axis_tdata[32:25] !== w.cell_at) report_mismatch("cell_attribute", m_axis_tdata[32:25], w.cell_at);
          if (m_axis_tdata[33]    !== w.refused) report_mismatch("refused", m_axis_tdata[33], w.refused);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: reset, config phases, directed then random items
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_status.size() > 0)
      @(negedge clk);
  endtask

  // register writes only with nothing in flight
  task automatic write_fill(logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fill_attr  = value;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    for (int i = 0; i < NCELLS; i++) begin
      shadow_screen[i] = '0;
      shadow_saved[i]  = '0;
      shadow_hist[i]   = '0;
    end
    cur_x = 0; cur_y = 0; view_back = 0; hist_head = 0; hist_fill = 0;
    fill_attr = FILL_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset state, view limits with no history, field extremes,
    // backspace cases, new lines, clear/snapshot/restore, reads out of range
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_READ, 8'hFF, 8'hFF, 5'd31, 7'd127);
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd23, 7'd80);
    queue_cmd(MODE_BS,   8'h00, 8'hFF, 5'd0, 7'd0);        // at origin
    queue_cmd(MODE_UP,   8'h00, 8'h00, 5'd0, 7'd0);        // no history
    queue_cmd(MODE_DOWN, 8'h00, 8'h00, 5'd0, 7'd0);        // already at zero
    queue_cmd(MODE_PUT,  8'hFF, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_PUT,  8'h00, 8'hFF, 5'd0, 7'd0);
    queue_cmd(MODE_PUT,  CH_LF, 8'h55, 5'd0, 7'd0);
    queue_cmd(MODE_PUT,  8'h41, 8'hAA, 5'd0, 7'd0);
    queue_cmd(MODE_PUT,  CH_CR, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_BS,   8'h00, 8'h3C, 5'd0, 7'd0);        // column zero, row above
    queue_cmd(MODE_BS,   8'h00, 8'hC3, 5'd0, 7'd0);        // mid line
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd0, 7'd79);
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_SNAP, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd12, 7'd40);
    queue_cmd(MODE_RESTORE, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    write_fill(8'h00);
    queue_op(MODE_CLEAR);
    queue_cmd(MODE_READ, 8'h00, 8'h00, 5'd23, 7'd79);

    write_fill(8'hFF);
    queue_op(MODE_CLEAR);
    queue_session(100);

    write_fill(8'($urandom));
    queue_session(100);

    write_fill(8'h00);
    queue_session(60);

    write_fill(FILL_RESET);
    wait_drained();
    quiet_tail = 1;
    queue_session(40);

    wait_drained();
    repeat (2000) @(posedge clk);
    if (error_count == 0 && expected_status.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
hdl/tt_pkg.sv
hdl/tt_sweep.sv
hdl/tt_store.sv
hdl/text_terminal_with_scrollback.sv
hdl/tt_checker.sv
tb/testbench.sv
